[rtl/fcgd_pkg.sv]
// ----------------------------------------------------------------------------
// fcgd_pkg
// Shared widths, constants, register indexes and pipeline control type for
// the four-channel gain and delay block.
// ----------------------------------------------------------------------------
package fcgd_pkg;

    // Channel layout
    localparam int CHANNELS  = 4;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 8;
    localparam int DELAY_W   = 12;
    localparam int TDATA_W   = CHANNELS * SAMPLE_W;

    // Delay line storage, per channel
    localparam int DELAY_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);
    localparam int WIDE_W      = ((DELAY_W > FILL_W) ? DELAY_W : FILL_W) + 1;

    // Gain product and divide-by-100 via reciprocal multiply
    localparam int     PROD_W       = SAMPLE_W + GAIN_W;
    localparam int     GAIN_DIVISOR = 100;
    localparam int     RECIP_SHIFT  = 30;
    localparam longint RECIP_MUL    =
        ((64'sd1 <<< RECIP_SHIFT) + GAIN_DIVISOR - 1) / GAIN_DIVISOR;
    localparam int     RECIP_W      = 24;
    localparam int     MUL_W        = PROD_W + RECIP_W;
    localparam int     QUO_W        = 17;

    // Saturation bounds
    localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [QUO_W-1:0]    QUO_POS_LIM = QUO_W'(SAT_MAX);
    localparam logic [QUO_W-1:0]    QUO_NEG_LIM = QUO_W'(SAT_MIN);

    // Register file
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = DELAY_W;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_FL  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_FR  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_RL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_RR  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_FL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_FR = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_RL = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_RR = 3'd7;
    localparam logic [GAIN_W-1:0]     GAIN_RESET   = 8'd100;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]   gain_t;
    typedef logic [DELAY_W-1:0]  delay_t;

    // Stage enables and shared write position, top to lanes
    typedef struct packed {
        logic              en1;
        logic              en2;
        logic              en3;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_idx;
        logic [FILL_W-1:0] fill;
    } pipe_ctrl_t;

endpackage

[rtl/four_channel_gain_delay.sv]
// ----------------------------------------------------------------------------
// four_channel_gain_delay
// Four-lane audio gain and delay: per channel percent gain, saturation to
// 16 bits and a delay line of up to DELAY_DEPTH-1 frames.
//
//   Port group   Beat content (low bits first)                 Handshake
//   s_*          fl_in, fr_in, rl_in, rr_in;                   tvalid/tready
//                tlast = block_last
//   m_*          fl_out, fr_out, rl_out, rr_out;               tvalid/tready
//                tlast = frame_last
//   cfg_*        register index, write data                    cfg_we strobe
//
// One frame per clock while m_tready stays high; a frame taken on s_* passes
// through the gain multiply, reciprocal multiply, RAM read and output
// registers in turn before it reaches m_*; the first loads on the taking edge.
// Each lane's delay RAM has one write and one read port, both used every
// frame. Reset clears control state and a fill count; no RAM clearing pass
// is run, the fill count masks entries not yet written to zero.
// A stalled output holds; each stage accepts new data while it is empty or draining.
// ----------------------------------------------------------------------------
module four_channel_gain_delay (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fcgd_pkg::TDATA_W-1:0]       s_tdata,  // fl_in, fr_in, rl_in, rr_in
    input  logic                               s_tlast,  // block_last
    // master side
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fcgd_pkg::TDATA_W-1:0]       m_tdata,  // fl_out, fr_out, rl_out, rr_out
    output logic                               m_tlast,  // frame_last
    // configuration
    input  logic                               cfg_we,
    input  logic [fcgd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fcgd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // Configuration registers
    fcgd_pkg::gain_t  gain_reg  [fcgd_pkg::CHANNELS];
    fcgd_pkg::delay_t delay_reg [fcgd_pkg::CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fcgd_pkg::CHANNELS; i++)
            begin
                gain_reg[i]  <= fcgd_pkg::GAIN_RESET;
                delay_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fcgd_pkg::REG_GAIN_FL:  gain_reg[0]  <= cfg_wdata[fcgd_pkg::GAIN_W-1:0];
                fcgd_pkg::REG_GAIN_FR:  gain_reg[1]  <= cfg_wdata[fcgd_pkg::GAIN_W-1:0];
                fcgd_pkg::REG_GAIN_RL:  gain_reg[2]  <= cfg_wdata[fcgd_pkg::GAIN_W-1:0];
                fcgd_pkg::REG_GAIN_RR:  gain_reg[3]  <= cfg_wdata[fcgd_pkg::GAIN_W-1:0];
                fcgd_pkg::REG_DELAY_FL: delay_reg[0] <= cfg_wdata;
                fcgd_pkg::REG_DELAY_FR: delay_reg[1] <= cfg_wdata;
                fcgd_pkg::REG_DELAY_RL: delay_reg[2] <= cfg_wdata;
                fcgd_pkg::REG_DELAY_RR: delay_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage valids and enables; a stage loads when empty or draining
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en_out;

    assign en_out = !out_valid_reg || m_tready;
    assign en3    = !v3_reg || en_out;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)    v1_reg        <= s_tvalid;
            if (en2)    v2_reg        <= v1_reg;
            if (en3)    v3_reg        <= v2_reg;
            if (en_out) out_valid_reg <= v3_reg;
        end
    end

    // Shared write position and fill count, one step per written frame; fill stops at DELAY_DEPTH
    logic                          wr_en;
    logic [fcgd_pkg::ADDR_W-1:0]   widx_reg, widx_next;
    logic [fcgd_pkg::FILL_W-1:0]   fill_reg, fill_next;

    assign wr_en     = en3 && v2_reg;
    assign widx_next = (widx_reg == fcgd_pkg::ADDR_W'(fcgd_pkg::DELAY_DEPTH - 1))
                       ? '0 : widx_reg + 1'b1;
    assign fill_next = (fill_reg == fcgd_pkg::FILL_W'(fcgd_pkg::DELAY_DEPTH))
                       ? fill_reg : fill_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg <= '0;
            fill_reg <= '0;
        end
        else if (wr_en)
        begin
            widx_reg <= widx_next;
            fill_reg <= fill_next;
        end
    end

    fcgd_pkg::pipe_ctrl_t ctrl;

    assign ctrl.en1    = en1;
    assign ctrl.en2    = en2;
    assign ctrl.en3    = en3;
    assign ctrl.wr_en  = wr_en;
    assign ctrl.wr_idx = widx_reg;
    assign ctrl.fill   = fill_reg;

    // Lanes
    fcgd_pkg::sample_t lane_out [fcgd_pkg::CHANNELS];

    for (genvar ch = 0; ch < fcgd_pkg::CHANNELS; ch++)
    begin : g_lane
        fcgd_lane u_lane (
            .clk        (clk),
            .ctrl       (ctrl),
            .sample_in  (s_tdata[ch*fcgd_pkg::SAMPLE_W +: fcgd_pkg::SAMPLE_W]),
            .gain       (gain_reg[ch]),
            .delay      (delay_reg[ch]),
            .sample_out (lane_out[ch])
        );
    end

    // Frame marker follows the lanes
    logic last1_reg, last2_reg, last3_reg;

    always_ff @(posedge clk)
    begin
        if (en1) last1_reg <= s_tlast;
        if (en2) last2_reg <= last1_reg;
        if (en3) last3_reg <= last2_reg;
    end

    // Merge lanes into the output register
    logic [fcgd_pkg::TDATA_W-1:0] tdata_next;
    logic [fcgd_pkg::TDATA_W-1:0] tdata_reg;
    logic                         tlast_reg;

    always_comb
    begin
        for (int i = 0; i < fcgd_pkg::CHANNELS; i++)
        begin
            tdata_next[i*fcgd_pkg::SAMPLE_W +: fcgd_pkg::SAMPLE_W] = lane_out[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            tdata_reg <= tdata_next;
            tlast_reg <= last3_reg;
        end
    end

    assign s_tready = en1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

[rtl/fcgd_ram.sv]
// ----------------------------------------------------------------------------
// fcgd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while read enable is low.
// ----------------------------------------------------------------------------
module fcgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fcgd_lane.sv]
// ----------------------------------------------------------------------------
// fcgd_lane
// One channel: percent gain with truncating divide by 100 and saturation,
// then a delay line held in a RAM with bypass for zero delay.
// ----------------------------------------------------------------------------
module fcgd_lane (
    input  logic                clk,
    input  fcgd_pkg::pipe_ctrl_t ctrl,
    input  fcgd_pkg::sample_t   sample_in,
    input  fcgd_pkg::gain_t     gain,
    input  fcgd_pkg::delay_t    delay,
    output fcgd_pkg::sample_t   sample_out
);

    // Stage 1: signed sample times unsigned gain, fits 24 bits signed
    logic signed [fcgd_pkg::PROD_W-1:0] prod_full;
    logic        [fcgd_pkg::PROD_W-1:0] prod_reg;

    assign prod_full = $signed(sample_in) * $signed({1'b0, gain});

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            prod_reg <= prod_full;
        end
    end

    // Stage 2: magnitude times reciprocal of 100, exact floor over this range
    logic [fcgd_pkg::PROD_W-1:0] mag;
    logic [fcgd_pkg::MUL_W-1:0]  mul_full;
    logic [fcgd_pkg::QUO_W-1:0]  quo_reg;
    logic                        neg_reg;

    assign mag = prod_reg[fcgd_pkg::PROD_W-1] ? (~prod_reg + 1'b1) : prod_reg;
    assign mul_full = fcgd_pkg::MUL_W'(mag) *
                      fcgd_pkg::MUL_W'(fcgd_pkg::RECIP_MUL);

    always_ff @(posedge clk)
    begin
        if (ctrl.en2)
        begin
            quo_reg <= mul_full[fcgd_pkg::RECIP_SHIFT +: fcgd_pkg::QUO_W];
            neg_reg <= prod_reg[fcgd_pkg::PROD_W-1];
        end
    end

    // Stage 3: restore sign and saturate
    fcgd_pkg::sample_t scaled;
    logic [fcgd_pkg::QUO_W-1:0] quo_neg;

    assign quo_neg = ~quo_reg + 1'b1;

    always_comb
    begin
        if (neg_reg)
        begin
            scaled = (quo_reg > fcgd_pkg::QUO_NEG_LIM) ? fcgd_pkg::SAT_MIN
                                                      : quo_neg[fcgd_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            scaled = (quo_reg > fcgd_pkg::QUO_POS_LIM) ? fcgd_pkg::SAT_MAX
                                                      : quo_reg[fcgd_pkg::SAMPLE_W-1:0];
        end
    end

    // Read position: clamp delay, step back from the write position
    logic [fcgd_pkg::WIDE_W-1:0] delay_eff;
    logic [fcgd_pkg::WIDE_W-1:0] widx_wide;
    logic [fcgd_pkg::WIDE_W-1:0] rd_wide;
    logic [fcgd_pkg::ADDR_W-1:0] rd_addr;

    assign delay_eff = (fcgd_pkg::WIDE_W'(delay) > fcgd_pkg::WIDE_W'(fcgd_pkg::DELAY_DEPTH - 1))
                       ? fcgd_pkg::WIDE_W'(fcgd_pkg::DELAY_DEPTH - 1)
                       : fcgd_pkg::WIDE_W'(delay);
    assign widx_wide = fcgd_pkg::WIDE_W'(ctrl.wr_idx);
    assign rd_wide   = (delay_eff > widx_wide)
                       ? widx_wide + fcgd_pkg::WIDE_W'(fcgd_pkg::DELAY_DEPTH) - delay_eff
                       : widx_wide - delay_eff;
    assign rd_addr   = rd_wide[fcgd_pkg::ADDR_W-1:0];

    // Delay line storage
    fcgd_pkg::sample_t rd_data;

    fcgd_ram #(
        .WIDTH (fcgd_pkg::SAMPLE_W),
        .DEPTH (fcgd_pkg::DELAY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .waddr (ctrl.wr_idx),
        .wdata (scaled),
        .re    (ctrl.en3),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Side data aligned with the registered read
    fcgd_pkg::sample_t scaled_reg;
    logic              bypass_reg;
    logic              unwritten_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en3)
        begin
            scaled_reg    <= scaled;
            bypass_reg    <= (delay_eff == '0);
            unwritten_reg <= (delay_eff > fcgd_pkg::WIDE_W'(ctrl.fill));
        end
    end

    // Zero delay passes through; entries not yet written read as zero
    assign sample_out = bypass_reg    ? scaled_reg :
                        unwritten_reg ? '0         : rd_data;

endmodule

[rtl/fcgd_checker.sv]
// ----------------------------------------------------------------------------
// fcgd_checker
// Port-level checks for the gain and delay block: output hold under stall,
// frame accounting and acceptance when empty.
// ----------------------------------------------------------------------------
module fcgd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fcgd_pkg::TDATA_W-1:0]  m_tdata,
    input logic                          m_tlast
);

    // Frames taken but not yet delivered
    logic [2:0] count_reg, count_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb
    begin
        count_next = count_reg;
        if (in_beat && !out_beat)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!in_beat && out_beat)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // No result without a frame in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> count_reg != 3'd0)
        else $error("output beat with no frame in flight");

    // At most four frames held in the pipeline
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("more frames in flight than pipeline stages");

    // An empty block always takes a frame
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 3'd0 |-> s_tready)
        else $error("empty block not ready");

endmodule

bind four_channel_gain_delay fcgd_checker u_fcgd_checker (.*);
